/* design/cau_pkg.sv */
// Shared types, codes and a helper function for the complex arithmetic unit.
package cau_pkg;

  localparam int W = 32;
  localparam int PW = 64;
  localparam int RW = 65;
  localparam int STEPS = 32;
  localparam int DEFAULT_FRAC_BITS = 16;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
  } sm_t;

  typedef struct packed {
    logic         sat;
    logic [W-1:0] val;
  } sres_t;

  // One divider or square-root lane as it moves down the iteration stages.
  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [W-1:0]  q;
    logic [PW-1:0] feed;
  } lane_t;

  typedef struct packed {
    logic [2:0]    op;
    logic          div_zero;
    logic [PW-1:0] den;
    lane_t         l0;
    lane_t         l1;
    logic [W-1:0]  re_pre;
    logic [W-1:0]  im_pre;
    logic [1:0]    st_pre;
  } step_t;

  // Clamp a sign-magnitude value to the 32-bit signed range.
  function automatic sres_t sat32(sm_t v);
    sres_t r;
    logic  hit;
    hit = v.neg ? (v.mag > PW'(64'h8000_0000)) : (v.mag > PW'(64'h7FFF_FFFF));
    r.sat = hit;
    if (hit) begin
      r.val = v.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.val = v.neg ? (~v.mag[W-1:0] + 32'd1) : v.mag[W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/cau_front.sv */
// Front pipeline: operand capture, products, sums and divider/square-root setup.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::DEFAULT_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output cau_pkg::step_t     out_data
);
  import cau_pkg::*;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  // stage 1: captured request
  logic [2:0] s1_op;
  logic signed [W-1:0] ar, ai, br, bi;

  // stage 2: products
  logic [2:0] s2_op;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic [PW-1:0] sq_a, sq_b;
  logic signed [W:0] as_re, as_im;

  // stage 3: sums in sign-magnitude form
  logic [2:0] s3_op;
  sm_t num_re, num_im;
  logic [PW-1:0] sq_sum;

  step_t s4, s4_next;

  logic signed [PW-1:0] prod_rr, prod_ii, prod_ri, prod_ir, prod_sa, prod_sb;
  logic signed [W-1:0] sqa_op, sqb_op;
  logic signed [65:0] v_re, v_im;
  sres_t sat_re, sat_im;
  logic [PW-1:0] q_re, q_im, hi_re, hi_im;

  function automatic sm_t to_sm(logic signed [65:0] v);
    sm_t r;
    logic signed [65:0] a;
    a = v[65] ? -v : v;
    r.neg = v[65];
    r.mag = a[PW-1:0];
    return r;
  endfunction

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = v4;
  assign out_data = s4;

  always_comb begin
    sqa_op = (s1_op == OP_MOD) ? ar : br;
    sqb_op = (s1_op == OP_MOD) ? ai : bi;
    prod_rr = PW'(ar) * PW'(br);
    prod_ii = PW'(ai) * PW'(bi);
    prod_ri = PW'(ar) * PW'(bi);
    prod_ir = PW'(ai) * PW'(br);
    prod_sa = PW'(sqa_op) * PW'(sqa_op);
    prod_sb = PW'(sqb_op) * PW'(sqb_op);
  end

  always_comb begin
    if (s2_op == OP_MUL) begin
      v_re = 66'(p_rr) - 66'(p_ii);
      v_im = 66'(p_ri) + 66'(p_ir);
    end else if (s2_op == OP_DIV) begin
      v_re = 66'(p_rr) + 66'(p_ii);
      v_im = 66'(p_ir) - 66'(p_ri);
    end else begin
      v_re = 66'(as_re);
      v_im = 66'(as_im);
    end
  end

  always_comb begin
    s4_next = '0;
    s4_next.op = s3_op;
    s4_next.st_pre = ST_OK;
    q_re = num_re.mag >> FRAC_BITS;
    q_im = num_im.mag >> FRAC_BITS;
    hi_re = num_re.mag >> (W - FRAC_BITS);
    hi_im = num_im.mag >> (W - FRAC_BITS);
    sat_re = sat32(num_re);
    sat_im = sat32(num_im);
    unique case (s3_op) inside
      OP_ADD, OP_SUB: begin
        s4_next.re_pre = sat_re.val;
        s4_next.im_pre = sat_im.val;
        s4_next.st_pre = (sat_re.sat || sat_im.sat) ? ST_SAT : ST_OK;
      end
      OP_MUL: begin
        sat_re = sat32('{neg: num_re.neg, mag: q_re});
        sat_im = sat32('{neg: num_im.neg, mag: q_im});
        s4_next.re_pre = sat_re.val;
        s4_next.im_pre = sat_im.val;
        s4_next.st_pre = (sat_re.sat || sat_im.sat) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        s4_next.den = sq_sum;
        if (sq_sum == '0) begin
          s4_next.div_zero = 1'b1;
          s4_next.st_pre = ST_DIVZ;
        end
        // quotient of (num << FRAC_BITS) / den, high part seeds the remainder
        s4_next.l0.neg = num_re.neg;
        s4_next.l0.ovf = hi_re >= sq_sum;
        s4_next.l0.rem = RW'(hi_re);
        s4_next.l0.feed = {num_re.mag[W-1:0] << FRAC_BITS, {W{1'b0}}};
        s4_next.l1.neg = num_im.neg;
        s4_next.l1.ovf = hi_im >= sq_sum;
        s4_next.l1.rem = RW'(hi_im);
        s4_next.l1.feed = {num_im.mag[W-1:0] << FRAC_BITS, {W{1'b0}}};
      end
      OP_MOD: begin
        s4_next.l0.feed = sq_sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_op <= req_type;
      ar <= a_real;
      ai <= a_imag;
      br <= b_real;
      bi <= b_imag;
    end
    if (r2) begin
      s2_op <= s1_op;
      p_rr <= prod_rr;
      p_ii <= prod_ii;
      p_ri <= prod_ri;
      p_ir <= prod_ir;
      sq_a <= prod_sa;
      sq_b <= prod_sb;
      as_re <= (s1_op == OP_SUB) ? (33'(ar) - 33'(br)) : (33'(ar) + 33'(br));
      as_im <= (s1_op == OP_SUB) ? (33'(ai) - 33'(bi)) : (33'(ai) + 33'(bi));
    end
    if (r3) begin
      s3_op <= s2_op;
      num_re <= to_sm(v_re);
      num_im <= to_sm(v_im);
      sq_sum <= sq_a + sq_b;
    end
    if (r4) begin
      s4 <= s4_next;
    end
  end

endmodule

/* design/cau_step.sv */
// One iteration stage: a quotient bit per lane, or a square-root bit on lane 0.
module cau_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cau_pkg::step_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cau_pkg::step_t out_data
);
  import cau_pkg::*;

  step_t nxt;
  logic [RW-1:0] rsh, trial;

  function automatic lane_t div_step(lane_t l, logic [PW-1:0] den);
    lane_t r;
    logic [RW-1:0] s;
    r = l;
    s = {l.rem[PW-1:0], l.feed[PW-1]};
    if (s >= {1'b0, den}) begin
      r.rem = s - {1'b0, den};
      r.q = {l.q[W-2:0], 1'b1};
    end else begin
      r.rem = s;
      r.q = {l.q[W-2:0], 1'b0};
    end
    r.feed = l.feed << 1;
    return r;
  endfunction

  always_comb begin
    nxt = in_data;
    rsh = {in_data.l0.rem[RW-3:0], in_data.l0.feed[PW-1:PW-2]};
    trial = RW'({in_data.l0.q, 2'b01});
    if (in_data.op == OP_MOD) begin
      if (rsh >= trial) begin
        nxt.l0.rem = rsh - trial;
        nxt.l0.q = {in_data.l0.q[W-2:0], 1'b1};
      end else begin
        nxt.l0.rem = rsh;
        nxt.l0.q = {in_data.l0.q[W-2:0], 1'b0};
      end
      nxt.l0.feed = in_data.l0.feed << 2;
    end else begin
      nxt.l0 = div_step(in_data.l0, in_data.den);
      nxt.l1 = div_step(in_data.l1, in_data.den);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

/* design/cau_back.sv */
// Output stage: final saturation of quotients and roots, result register.
module cau_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cau_pkg::step_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_real,
  output logic signed [31:0] res_imag,
  output logic [1:0]         status
);
  import cau_pkg::*;

  logic [W-1:0] re_n, im_n;
  logic [1:0] st_n;
  sres_t q_re, q_im;

  function automatic sres_t lane_res(lane_t l);
    sres_t r;
    if (l.ovf) begin
      r.sat = 1'b1;
      r.val = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = sat32('{neg: l.neg, mag: PW'(l.q)});
    end
    return r;
  endfunction

  always_comb begin
    q_re = lane_res(in_data.l0);
    q_im = lane_res(in_data.l1);
    re_n = in_data.re_pre;
    im_n = in_data.im_pre;
    st_n = in_data.st_pre;
    if (in_data.op == OP_DIV && !in_data.div_zero) begin
      re_n = q_re.val;
      im_n = q_im.val;
      st_n = (q_re.sat || q_im.sat) ? ST_SAT : ST_OK;
    end else if (in_data.op == OP_MOD) begin
      q_re = sat32('{neg: 1'b0, mag: PW'(in_data.l0.q)});
      re_n = q_re.val;
      im_n = '0;
      st_n = q_re.sat ? ST_SAT : ST_OK;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      res_real <= re_n;
      res_imag <= im_n;
      status <= st_n;
    end
  end

endmodule

/* design/complex_arithmetic_unit_core.sv */
// Top level of the complex arithmetic unit: front stages, iteration stages, output stage.
//
//   port group  direction  handshake            payload
//   request     in         in_valid / in_ready  req_type, a_real, a_imag, b_real, b_imag
//   result      out        out_valid/out_ready  res_real, res_imag, status
//
// One request per cycle unless a stalled result has filled the stages up to the input.
// The request passes 37 register stages: four front stages, the 32-stage
// divider/square-root pipeline (one quotient or root bit per stage) and the output register.
// Synchronous reset empties all stages. Each stage advances when it is empty or the
// next one takes its contents, so a stalled result holds only the stages behind it.
module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS = cau_pkg::DEFAULT_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_real,
  output logic signed [31:0] res_imag,
  output logic [1:0]         status
);
  import cau_pkg::*;

  step_t stg_data [STEPS+1];
  logic  stg_valid [STEPS+1];
  logic  stg_ready [STEPS+1];

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .a_real    (a_real),
    .a_imag    (a_imag),
    .b_real    (b_real),
    .b_imag    (b_imag),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cau_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[STEPS]),
    .in_ready  (stg_ready[STEPS]),
    .in_data   (stg_data[STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_real  (res_real),
    .res_imag  (res_imag),
    .status    (status)
  );

endmodule

/* design/cau_check.sv */
// Port-level checker for the complex arithmetic unit, bound to the top level.
module cau_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         req_type,
  input logic signed [31:0] a_real,
  input logic signed [31:0] a_imag,
  input logic signed [31:0] b_real,
  input logic signed [31:0] b_imag,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] res_real,
  input logic signed [31:0] res_imag,
  input logic [1:0]         status
);
  import cau_pkg::*;

  // reset leaves no result valid
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_real) && $stable(res_imag)
      && $stable(status))
    else $error("stalled result changed");

  // an open output slot lets a request in
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("request blocked while output can move");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_DIVZ))
    else $error("bad status code");

  a_divz: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DIVZ |-> res_real == 0 && res_imag == 0)
    else $error("division by zero with nonzero result");

endmodule

bind complex_arithmetic_unit_core cau_check u_cau_check (.*);
